// File: rtl/db4dwt_pkg.sv
// db4dwt_pkg: shared constants, sequencer state type and the Q1.15 db4 filter
// tables for the one-level db4 wavelet analysis block.
// No dependencies.
package db4dwt_pkg;

   // Width of the approximation and detail results
   localparam int OUT_BITS = 26;

   // Sequencer states: fill the head buffer, stream samples, replay the
   // front mirror, drain the tail mirror and the filter run-out
   typedef enum logic [3:0] {
      ST_FILL = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_HEAD = 4'b0100,
      ST_TAIL = 4'b1000
   } state_type;

   // Low-pass db4 taps in Q1.15, zero past the eighth tap
   function automatic int lo_q15(input int idx);
      int c;
      unique case (idx)
         0:       c = -347;
         1:       c = 1078;
         2:       c = 1011;
         3:       c = -6129;
         4:       c = -917;
         5:       c = 20673;
         6:       c = 23424;
         7:       c = 7549;
         default: c = 0;
      endcase
      return c;
   endfunction

   // High-pass db4 taps in Q1.15, zero past the eighth tap
   function automatic int hi_q15(input int idx);
      int c;
      unique case (idx)
         0:       c = -7549;
         1:       c = 23424;
         2:       c = -20673;
         3:       c = -917;
         4:       c = 6129;
         5:       c = 1011;
         6:       c = -1078;
         7:       c = -347;
         default: c = 0;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/db4_dwt_one_level.sv
// db4_dwt_one_level: one level of db4 wavelet analysis over sample blocks.
// Depends on db4dwt_pkg (result width, state type, Q1.15 filter taps).
//
// Usage:
//   req_* channel takes one signed sample per beat; req_last marks the final
//   sample of a block. rsp_* channel returns (approx, detail) pairs, one for
//   every even position of the mirror-padded, fully convolved block;
//   rsp_final_res marks the last pair of a block. A block shorter than
//   TAPS/2+1 samples returns a single beat with status 1, zero data and
//   final_res set.
//   Pipeline: a result formed in a step passes one product register, then
//   one sum/round register, before it appears on rsp.
//   Throughput: in the body of a block one sample is taken every cycle
//   but for receiver stalls. The first TAPS/2 samples are only buffered;
//   the next starts a replay of 2*TAPS/2 values (8 at TAPS=8), a last
//   sample a drain of TAPS/2+TAPS-1 values (11 at TAPS=8). req_ready is
//   low during both: the single tap line takes one padded value a cycle.
//   Reset: synchronous, active high; clears the sequencer, tap line and
//   the valid flags of both pipeline stages. The head buffer needs no reset.
//   Receiver stall: results wait in the rsp register and the product
//   stage; odd positions still advance, and req_ready drops when a new
//   pair has no free stage to enter, and also while the head of a block
//   is being buffered and the product stage is full.
module db4_dwt_one_level #(
   parameter int TAPS           = 8,
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [SAMPLE_BITS-1:0]            req_sample,
   input  logic                                     req_last,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [db4dwt_pkg::OUT_BITS-1:0]   rsp_approx,
   output logic signed [db4dwt_pkg::OUT_BITS-1:0]   rsp_detail,
   output logic                                     rsp_final_res,
   output logic                                     rsp_status
);

   localparam int OB        = db4dwt_pkg::OUT_BITS;
   localparam int PAD       = TAPS / 2;
   localparam int HEAD_LEN  = 2 * PAD;
   localparam int TLEN      = PAD + TAPS - 1;
   localparam int HW        = $clog2(PAD + 1);
   localparam int KW        = $clog2(TLEN);
   localparam int CW        = COEF_FRAC_BITS + 1;
   localparam int PW        = SAMPLE_BITS + CW;
   localparam int AW        = PW + $clog2(TAPS);
   localparam int RW        = (AW > OB) ? AW : OB + 1;

   localparam logic signed [RW-1:0] HALF   = RW'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [RW-1:0] SAT_HI = {{(RW - OB + 1){1'b0}}, {(OB - 1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

   // Scale a Q1.15 tap to COEF_FRAC_BITS, rounding half up when narrowing
   function automatic int scale_coef(input int c);
      int r;
      if (COEF_FRAC_BITS >= 15) begin
         r = c <<< (COEF_FRAC_BITS - 15);
      end else begin
         r = (c + (1 <<< (14 - COEF_FRAC_BITS))) >>> (15 - COEF_FRAC_BITS);
      end
      return r;
   endfunction

   // Round half up by COEF_FRAC_BITS and clamp to the result width
   function automatic logic signed [OB-1:0] round_sat(input logic signed [AW-1:0] acc);
      logic signed [RW-1:0] ext;
      logic signed [RW-1:0] rnd;
      logic signed [OB-1:0] res;
      ext = RW'(acc);
      rnd = (ext + HALF) >>> COEF_FRAC_BITS;
      if (rnd > SAT_HI) begin
         res = SAT_HI[OB-1:0];
      end else if (rnd < SAT_LO) begin
         res = SAT_LO[OB-1:0];
      end else begin
         res = rnd[OB-1:0];
      end
      return res;
   endfunction

   // Sequencer and tap line state
   db4dwt_pkg::state_type         state_ff, state_in;
   logic [HW-1:0]                 cnt_ff, cnt_in;
   logic [KW-1:0]                 k_ff, k_in;
   logic                          parity_ff, parity_in;
   logic                          last_pend_ff, last_pend_in;
   logic signed [SAMPLE_BITS-1:0] tap_ff [TAPS-1];
   logic signed [SAMPLE_BITS-1:0] tap_in [TAPS-1];
   logic signed [SAMPLE_BITS-1:0] tail_ff [PAD];
   logic signed [SAMPLE_BITS-1:0] tail_in [PAD];
   logic signed [SAMPLE_BITS-1:0] head_ff [PAD+1];

   // Step controls
   logic                          req_fire;
   logic                          head_we;
   logic                          push_en;
   logic signed [SAMPLE_BITS-1:0] push_val;
   logic                          tail_start;
   logic                          block_done;
   logic                          emit;
   logic                          emit_err;
   logic                          emit_final;
   logic [HW-1:0]                 head_idx;
   logic signed [SAMPLE_BITS-1:0] win [TAPS];

   // Product stage
   logic                          a_ready;
   logic                          a_valid_ff;
   logic                          a_final_ff;
   logic                          a_status_ff;
   logic signed [PW-1:0]          prod_lo_in [TAPS];
   logic signed [PW-1:0]          prod_hi_in [TAPS];
   logic signed [PW-1:0]          prod_lo_ff [TAPS];
   logic signed [PW-1:0]          prod_hi_ff [TAPS];

   // Result stage
   logic                          b_ready;
   logic                          rsp_valid_ff;
   logic signed [OB-1:0]          rsp_approx_ff;
   logic signed [OB-1:0]          rsp_detail_ff;
   logic                          rsp_final_ff;
   logic                          rsp_status_ff;
   logic signed [AW-1:0]          sum_lo;
   logic signed [AW-1:0]          sum_hi;

   assign b_ready  = !rsp_valid_ff || rsp_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign req_fire = req_valid && req_ready;

   // Replay order of the front mirror: x(PAD-1)..x0, then x1..x(PAD)
   always_comb begin
      if (int'(k_ff) < PAD) begin
         head_idx = HW'(PAD - 1 - int'(k_ff));
      end else begin
         head_idx = HW'(int'(k_ff) - PAD + 1);
      end
   end

   // Sequence padded values into the tap line
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      parity_in    = parity_ff;
      last_pend_in = last_pend_ff;
      tap_in       = tap_ff;
      tail_in      = tail_ff;
      req_ready    = 1'b0;
      head_we      = 1'b0;
      push_en      = 1'b0;
      push_val     = '0;
      tail_start   = 1'b0;
      block_done   = 1'b0;
      emit_err     = 1'b0;
      emit_final   = 1'b0;

      unique case (state_ff)
         db4dwt_pkg::ST_FILL: begin
            req_ready = a_ready;
            if (req_fire) begin
               head_we = 1'b1;
               if (cnt_ff == HW'(PAD)) begin
                  push_en      = 1'b1;
                  push_val     = req_sample;
                  k_in         = '0;
                  last_pend_in = req_last;
                  state_in     = db4dwt_pkg::ST_HEAD;
               end else if (req_last) begin
                  emit_err   = 1'b1;
                  emit_final = 1'b1;
                  cnt_in     = '0;
               end else begin
                  cnt_in = cnt_ff + HW'(1);
               end
            end
         end
         db4dwt_pkg::ST_RUN: begin
            req_ready = parity_ff || a_ready;
            if (req_fire) begin
               push_en  = 1'b1;
               push_val = req_sample;
               if (req_last) begin
                  tail_start = 1'b1;
                  k_in       = '0;
                  state_in   = db4dwt_pkg::ST_TAIL;
               end
            end
         end
         db4dwt_pkg::ST_HEAD: begin
            if (parity_ff || a_ready) begin
               push_en  = 1'b1;
               push_val = head_ff[head_idx];
               k_in     = k_ff + KW'(1);
               if (k_ff == KW'(HEAD_LEN - 1)) begin
                  k_in = '0;
                  if (last_pend_ff) begin
                     tail_start = 1'b1;
                     state_in   = db4dwt_pkg::ST_TAIL;
                  end else begin
                     state_in = db4dwt_pkg::ST_RUN;
                  end
               end
            end
         end
         db4dwt_pkg::ST_TAIL: begin
            if (parity_ff || a_ready) begin
               push_en    = 1'b1;
               push_val   = tail_ff[0];
               emit_final = (k_ff >= KW'(TLEN - 2));
               for (int i = 0; i < PAD - 1; i++) begin
                  tail_in[i] = tail_ff[i+1];
               end
               tail_in[PAD-1] = '0;
               k_in           = k_ff + KW'(1);
               if (k_ff == KW'(TLEN - 1)) begin
                  block_done = 1'b1;
                  k_in       = '0;
                  cnt_in     = '0;
                  state_in   = db4dwt_pkg::ST_FILL;
               end
            end
         end
         default: begin
            state_in = db4dwt_pkg::ST_FILL;
         end
      endcase

      // Advance the tap line by one padded value
      if (push_en) begin
         for (int i = 0; i < TAPS - 2; i++) begin
            tap_in[i] = tap_ff[i+1];
         end
         tap_in[TAPS-2] = push_val;
         parity_in      = !parity_ff;
      end

      // Snapshot the last PAD values, newest first, for the end mirror
      if (tail_start) begin
         for (int i = 0; i < PAD; i++) begin
            tail_in[i] = tap_in[TAPS-2-i];
         end
      end

      // Return to the empty-block state
      if (block_done) begin
         parity_in = 1'b0;
         for (int i = 0; i < TAPS - 1; i++) begin
            tap_in[i] = '0;
         end
      end
   end

   assign emit = (push_en && !parity_ff) || emit_err;

   // Assemble the filter window; an error beat carries zeros
   always_comb begin
      win[0] = emit_err ? '0 : push_val;
      for (int j = 1; j < TAPS; j++) begin
         win[j] = emit_err ? '0 : tap_ff[TAPS-1-j];
      end
   end

   // Multiply the window by the fixed low-pass and high-pass taps
   for (genvar j = 0; j < TAPS; j++) begin : g_prod
      localparam int CL = scale_coef(db4dwt_pkg::lo_q15(j));
      localparam int CH = scale_coef(db4dwt_pkg::hi_q15(j));
      logic signed [PW-1:0] wx;
      assign wx            = PW'(win[j]);
      assign prod_lo_in[j] = wx * PW'(CL);
      assign prod_hi_in[j] = wx * PW'(CH);
   end

   // Add up the products
   always_comb begin
      sum_lo = '0;
      sum_hi = '0;
      for (int j = 0; j < TAPS; j++) begin
         sum_lo = sum_lo + AW'(prod_lo_ff[j]);
         sum_hi = sum_hi + AW'(prod_hi_ff[j]);
      end
   end

   // Sequencer and tap line registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= db4dwt_pkg::ST_FILL;
         cnt_ff       <= '0;
         k_ff         <= '0;
         parity_ff    <= 1'b0;
         last_pend_ff <= 1'b0;
         for (int i = 0; i < TAPS - 1; i++) begin
            tap_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         parity_ff    <= parity_in;
         last_pend_ff <= last_pend_in;
         tap_ff       <= tap_in;
      end
   end

   // Head buffer and tail snapshot, payload only
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[cnt_ff] <= req_sample;
      end
      tail_ff <= tail_in;
   end

   // Product stage: load a new pair when it enters, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && a_ready) begin
         prod_lo_ff  <= prod_lo_in;
         prod_hi_ff  <= prod_hi_in;
         a_final_ff  <= emit_final;
         a_status_ff <= emit_err;
      end
   end

   // Result stage: round, clamp and hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_ready) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         rsp_approx_ff <= round_sat(sum_lo);
         rsp_detail_ff <= round_sat(sum_hi);
         rsp_final_ff  <= a_final_ff;
         rsp_status_ff <= a_status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_approx    = rsp_approx_ff;
   assign rsp_detail    = rsp_detail_ff;
   assign rsp_final_res = rsp_final_ff;
   assign rsp_status    = rsp_status_ff;

   // A new pair never lands on a stage that cannot move
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> a_ready)
      else $error("pair formed while the product stage is blocked");

   // A short-block beat is a zero pair that closes the block
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_final_res && rsp_approx == '0 && rsp_detail == '0))
      else $error("short-block beat carries data or lacks the final mark");

   // Buffering always starts at an even position
   a_fill_even: assert property (@(posedge clock) disable iff (reset)
      (state_ff == db4dwt_pkg::ST_FILL) |-> !parity_ff)
      else $error("odd position while buffering the head of a block");

   // After the drain the tap line is empty again
   a_drain_clear: assert property (@(posedge clock) disable iff (reset)
      block_done |=> (tap_ff[0] == '0 && tap_ff[TAPS-2] == '0 && !parity_ff))
      else $error("tap line not cleared at the end of a block");

endmodule

// File: sim/dwt_result_checker.sv
// dwt_result_checker: watches the sample and result channels of the db4
// one-level wavelet block, predicts every (approx, detail) beat and compares.
// Depends on db4dwt_pkg for the result width.
module dwt_result_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   input  logic                                   req_last,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [db4dwt_pkg::OUT_BITS-1:0] rsp_approx,
   input  logic signed [db4dwt_pkg::OUT_BITS-1:0] rsp_detail,
   input  logic                                   rsp_final_res,
   input  logic                                   rsp_status,
   output int                                     failures,
   output int                                     pending,
   output int                                     checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RES_BITS    = db4dwt_pkg::OUT_BITS;
   localparam int FILTER_TAPS = 8;
   localparam int EDGE_PAD    = FILTER_TAPS / 2;
   localparam int HEAD_DEPTH  = EDGE_PAD + 1;
   localparam int FRAC_BITS   = 15;
   localparam int REPORT_CAP  = 40;
   localparam longint OUT_MAX = (longint'(1) <<< (RES_BITS - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   typedef struct {
      logic signed [RES_BITS-1:0] approx;
      logic signed [RES_BITS-1:0] detail;
      logic                       final_res;
      logic                       status;
   } coef_pair_type;

   // db4 low-pass in Q1.15; the high-pass is its alternating-sign mirror
   longint lowpass_tap [0:FILTER_TAPS-1] = '{-347, 1078, 1011, -6129, -917, 20673, 23424, 7549};
   longint highpass_tap [0:FILTER_TAPS-1];

   coef_pair_type expected_pairs [$];
   longint        head_buf [0:HEAD_DEPTH-1];
   longint        history [0:FILTER_TAPS-2];
   int            head_count;
   bit            odd_position;

   initial begin
      failures = 0;
      pending  = 0;
      checked  = 0;
      for (int n = 0; n < FILTER_TAPS; n++) begin
         highpass_tap[n] = (n % 2 == 0) ? -lowpass_tap[FILTER_TAPS-1-n]
                                        :  lowpass_tap[FILTER_TAPS-1-n];
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      failures++;
      if (failures <= REPORT_CAP)
         $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // Round half up out of Q.15 and clamp to the result width
   function automatic logic signed [RES_BITS-1:0] round_q15(input longint acc);
      longint r;
      r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return r[RES_BITS-1:0];
   endfunction

   task automatic clear_block();
      for (int k = 0; k < FILTER_TAPS - 1; k++) history[k] = 0;
      head_count   = 0;
      odd_position = 1'b0;
   endtask

   // Shift one padded value into the filter; even positions yield a pair
   task automatic feed_filter(input longint value);
      longint        acc_lo;
      longint        acc_hi;
      coef_pair_type pair;
      if (!odd_position) begin
         acc_lo = value * lowpass_tap[0];
         acc_hi = value * highpass_tap[0];
         for (int j = 1; j < FILTER_TAPS; j++) begin
            acc_lo += history[FILTER_TAPS-1-j] * lowpass_tap[j];
            acc_hi += history[FILTER_TAPS-1-j] * highpass_tap[j];
         end
         pair.approx    = round_q15(acc_lo);
         pair.detail    = round_q15(acc_hi);
         pair.final_res = 1'b0;
         pair.status    = 1'b0;
         expected_pairs.push_back(pair);
      end
      for (int k = 0; k < FILTER_TAPS - 2; k++) history[k] = history[k+1];
      history[FILTER_TAPS-2] = value;
      odd_position = !odd_position;
   endtask

   // Predict all pairs caused by one accepted sample beat
   task automatic take_sample(input longint value, input bit is_last);
      longint        tail [0:EDGE_PAD-1];
      coef_pair_type short_pair;
      if (head_count < HEAD_DEPTH) begin
         head_buf[head_count] = value;
         head_count++;
         // head complete: replay the front mirror, then the buffered samples
         if (head_count == HEAD_DEPTH) begin
            for (int i = 0; i < EDGE_PAD; i++) feed_filter(head_buf[EDGE_PAD-i]);
            for (int i = 0; i <= EDGE_PAD; i++) feed_filter(head_buf[i]);
         end
      end else begin
         feed_filter(value);
      end

      if (is_last) begin
         if (head_count < HEAD_DEPTH) begin
            short_pair.approx    = '0;
            short_pair.detail    = '0;
            short_pair.final_res = 1'b1;
            short_pair.status    = 1'b1;
            expected_pairs.push_back(short_pair);
         end else begin
            // tail mirror includes the edge sample, then flush with zeros
            for (int i = 0; i < EDGE_PAD; i++) tail[i] = history[FILTER_TAPS-2-i];
            for (int i = 0; i < EDGE_PAD; i++) feed_filter(tail[i]);
            for (int i = 0; i < FILTER_TAPS - 1; i++) feed_filter(0);
            expected_pairs[expected_pairs.size()-1].final_res = 1'b1;
         end
         clear_block();
      end
   endtask

   // Check result beats against the oldest prediction, then predict new ones
   always @(posedge clock) begin : monitor
      coef_pair_type want;
      if (reset) begin
         clear_block();
         expected_pairs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_pairs.size() == 0) begin
               report("result beat with nothing expected", rsp_approx, 0);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_approx !== want.approx)
                  report("approx", rsp_approx, want.approx);
               if (rsp_detail !== want.detail)
                  report("detail", rsp_detail, want.detail);
               if (rsp_final_res !== want.final_res)
                  report("final_res", rsp_final_res, want.final_res);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready)
            take_sample(longint'(req_sample), req_last);
      end
      pending = expected_pairs.size();
   end

endmodule

// File: sim/tb.sv
// tb: stimulus and verdict for db4_dwt_one_level; directed short, minimal and
// extreme blocks, then random blocks with random gaps and receiver stalls.
// Depends on db4dwt_pkg, db4_dwt_one_level and dwt_result_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS      = 24;
   localparam int RANDOM_SAMPLES   = 250;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int HOLD_AFTER       = 120;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 400000;
   localparam logic signed [SAMPLE_BITS-1:0] MAX_SAMPLE = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE = 24'sh800000;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [SAMPLE_BITS-1:0]          req_sample = '0;
   logic                                   req_last = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [db4dwt_pkg::OUT_BITS-1:0] rsp_approx;
   logic signed [db4dwt_pkg::OUT_BITS-1:0] rsp_detail;
   logic                                   rsp_final_res;
   logic                                   rsp_status;

   int  failures;
   int  pending;
   int  checked;
   int  sent_samples = 0;
   int  blocks_sent = 0;
   int  short_blocks = 0;
   int  cycle_count = 0;
   bit  hold_request = 1'b0;
   bit  hold_issued = 1'b0;

   logic signed [SAMPLE_BITS-1:0] block_q [$];

   db4_dwt_one_level #(
      .TAPS           (8),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (15)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_approx    (rsp_approx),
      .rsp_detail    (rsp_detail),
      .rsp_final_res (rsp_final_res),
      .rsp_status    (rsp_status)
   );

   dwt_result_checker #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_approx    (rsp_approx),
      .rsp_detail    (rsp_detail),
      .rsp_final_res (rsp_final_res),
      .rsp_status    (rsp_status),
      .failures      (failures),
      .pending       (pending),
      .checked       (checked)
   );

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   // End the run if it stalls far past the slowest legal run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // Send the samples held in block_q as one block, last flag on the final beat
   task automatic send_block(input bit no_gaps);
      int gap;
      int pick;
      for (int i = 0; i < block_q.size(); i++) begin
         gap = 0;
         if (!no_gaps) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      gap = 0;
            else if (pick < 90) gap = $urandom_range(1, 3);
            else if (pick < 97) gap = $urandom_range(4, 10);
            else                gap = $urandom_range(20, 60);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid  <= 1'b1;
         req_sample <= block_q[i];
         req_last   <= (i == block_q.size() - 1);
         // hold the beat until the block takes it
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
         sent_samples++;
      end
      blocks_sent++;
      if (block_q.size() < 5) short_blocks++;
   endtask

   // Result side: ready runs, short and long stalls, one long hold-off on request
   initial begin : receiver
      int run_len;
      int mode;
      int hold_cycles;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_cycles = 0;
            while (hold_cycles < HOLD_OFF_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
               hold_cycles++;
            end
            hold_request = 1'b0;
         end else begin
            mode = $urandom_range(0, 9);
            if (mode == 8)      run_len = $urandom_range(1, 3);
            else if (mode == 9) run_len = $urandom_range(10, 50);
            else                run_len = $urandom_range(4, 40);
            repeat (run_len) begin
               if (mode < 4)      rsp_ready <= 1'b1;
               else if (mode < 8) rsp_ready <= ($urandom_range(0, 3) != 0);
               else               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int random_sent;
      int len;
      int pick;
      bit no_gaps;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: short blocks of every length, then minimal and mirrored blocks
      block_q = {MAX_SAMPLE};
      send_block(1'b1);
      block_q = {MIN_SAMPLE, 24'sd1};
      send_block(1'b0);
      block_q = {24'sd0, -24'sd1, MAX_SAMPLE};
      send_block(1'b1);
      block_q = {MAX_SAMPLE, MIN_SAMPLE, MAX_SAMPLE, MIN_SAMPLE};
      send_block(1'b0);
      block_q = {MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE};
      send_block(1'b1);
      block_q = {MIN_SAMPLE, MAX_SAMPLE, MIN_SAMPLE, MAX_SAMPLE, MIN_SAMPLE, MAX_SAMPLE};
      send_block(1'b0);

      // Random blocks, mostly well formed, with a few short ones mixed in
      random_sent = 0;
      while (random_sent < RANDOM_SAMPLES) begin
         pick = $urandom_range(0, 19);
         if (pick < 2)       len = $urandom_range(1, 4);
         else if (pick < 4)  len = $urandom_range(5, 6);
         else if (pick < 17) len = $urandom_range(7, 20);
         else                len = $urandom_range(21, 40);
         block_q.delete();
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0:       block_q.push_back(MAX_SAMPLE);
               1:       block_q.push_back(MIN_SAMPLE);
               2, 3:    block_q.push_back(SAMPLE_BITS'($urandom_range(0, 2000)) - 24'sd1000);
               default: block_q.push_back(SAMPLE_BITS'($urandom));
            endcase
         end
         // one long receiver hold-off while samples keep coming
         if (!hold_issued && random_sent >= HOLD_AFTER) begin
            hold_issued  = 1'b1;
            hold_request = 1'b1;
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         send_block(no_gaps);
         random_sent += len;
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then allow for stray beats
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d samples in %0d blocks (%0d short); checked %0d result beats",
               sent_samples, blocks_sent, short_blocks, checked);
      $display("Included a %0d-cycle receiver hold-off; %0d mismatches",
               HOLD_OFF_CYCLES, failures);
      if (failures == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/db4dwt_pkg.sv
rtl/db4_dwt_one_level.sv
sim/dwt_result_checker.sv
sim/tb.sv
